@@ hdl/tea_pkg.sv @@
// Shared types, constants and round functions of the TEA block cipher unit.
package tea_pkg;

  // Golden-ratio step added to the running sum in every round
  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

  // Default number of full rounds
  localparam int unsigned ROUNDS_DEFAULT = 32;

  // Width of the configuration register index and data
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD0    = 3'd0,
    CFG_KEY_WORD1    = 3'd1,
    CFG_KEY_WORD2    = 3'd2,
    CFG_KEY_WORD3    = 3'd3,
    CFG_DECRYPT_MODE = 3'd4
  } cfg_idx_e;

  // One 64-bit block as its two halves
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
  } blk_t;

  // Key and mode as seen by every cell
  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
    logic        decrypt;
  } cfg_t;

  // Running sum after n rounds, modulo 2^32 (elaboration-time only)
  function automatic logic [31:0] round_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(n);
    return prod[31:0];
  endfunction

  // TEA mixing function of one half round
  function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

@@ hdl/tea_block_cipher_unit.sv @@
// Top level of the TEA block cipher unit: configuration registers and a chain of round cells.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_ready_o   block_word_first_i, block_word_second_i
//   output   out        out_valid_o / out_ready_i out_word_first_o, out_word_second_o
//   config   in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Each block passes through 2*ROUNDS cells, one half round per cell, and one block enters
// every cycle unless a stalled output has backed the chain up to the input.
// The last cell is the output register; a stalled output stops only the cells behind
// it that are full, so bubbles still fill while a result waits.
// Reset clears the cell valid bits, the key to zero and the mode to encrypt.
module tea_block_cipher_unit #(
  parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tea_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [31:0]                    block_word_first_i,
  input  logic [31:0]                    block_word_second_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    out_word_first_o,
  output logic [31:0]                    out_word_second_o
);

  localparam int unsigned NumCells = 2 * ROUNDS;

  tea_pkg::cfg_t cfg;
  logic          valid [NumCells+1];
  logic          ready [NumCells+1];
  tea_pkg::blk_t blk   [NumCells+1];

  tea_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Feed the head of the chain
  assign valid[0]  = in_valid_i;
  assign blk[0].w0 = block_word_first_i;
  assign blk[0].w1 = block_word_second_i;
  assign in_ready_o = ready[0];

  // Build the chain; each cell uses the round sum fixed by its position
  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    localparam int unsigned Round = c / 2;
    tea_round_cell #(
      .HALF    (1'(c % 2)),
      .SUM_ENC (tea_pkg::round_sum(Round + 1)),
      .SUM_DEC (tea_pkg::round_sum(ROUNDS - Round))
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg),
      .in_valid_i  (valid[c]),
      .in_ready_o  (ready[c]),
      .in_blk_i    (blk[c]),
      .out_valid_o (valid[c+1]),
      .out_ready_i (ready[c+1]),
      .out_blk_o   (blk[c+1])
    );
  end

  // Drive the output from the last cell
  assign ready[NumCells]  = out_ready_i;
  assign out_valid_o      = valid[NumCells];
  assign out_word_first_o  = blk[NumCells].w0;
  assign out_word_second_o = blk[NumCells].w1;

`ifndef NO_ASSERTIONS
  // Input backpressure only comes from a full chain behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result at the output");
`endif

endmodule

@@ hdl/tea_cfg_regs.sv @@
// Configuration registers of the TEA block cipher unit: key words and mode.
module tea_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tea_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tea_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output tea_pkg::cfg_t                    cfg_o
);

  tea_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; ignore indexes beyond the register list
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tea_pkg::CFG_KEY_WORD0:    cfg_d.k0      = cfg_wdata_i[31:0];
        tea_pkg::CFG_KEY_WORD1:    cfg_d.k1      = cfg_wdata_i[31:0];
        tea_pkg::CFG_KEY_WORD2:    cfg_d.k2      = cfg_wdata_i[31:0];
        tea_pkg::CFG_KEY_WORD3:    cfg_d.k3      = cfg_wdata_i[31:0];
        tea_pkg::CFG_DECRYPT_MODE: cfg_d.decrypt = cfg_wdata_i[0];
        default:                   cfg_d         = cfg_q;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

`ifndef NO_ASSERTIONS
  // Mode write keeps bit 0 of the data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == tea_pkg::CFG_DECRYPT_MODE) |=>
      cfg_q.decrypt == $past(cfg_wdata_i[0]))
    else $error("mode register did not take bit 0 of the write data");
`endif

endmodule

@@ hdl/tea_round_cell.sv @@
// One half-round cell of the TEA pipeline: updates one block half and passes it on.
module tea_round_cell #(
  parameter bit          HALF    = 1'b0,
  parameter logic [31:0] SUM_ENC = tea_pkg::TEA_DELTA,
  parameter logic [31:0] SUM_DEC = tea_pkg::TEA_DELTA
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tea_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tea_pkg::blk_t in_blk_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tea_pkg::blk_t out_blk_o
);

  logic          valid_q, valid_d;
  tea_pkg::blk_t blk_q, blk_d;
  logic          update_first;
  logic [31:0]   src, tgt, ka, kb, sum, mix, res;

  // Pick which half this cell updates and from which key pair
  always_comb begin
    update_first = (cfg_i.decrypt == HALF);
    src = update_first ? in_blk_i.w1 : in_blk_i.w0;
    tgt = update_first ? in_blk_i.w0 : in_blk_i.w1;
    ka  = update_first ? cfg_i.k0 : cfg_i.k2;
    kb  = update_first ? cfg_i.k1 : cfg_i.k3;
    sum = cfg_i.decrypt ? SUM_DEC : SUM_ENC;
    mix = tea_pkg::tea_mix(src, sum, ka, kb);
    res = cfg_i.decrypt ? (tgt - mix) : (tgt + mix);
  end

  // Advance when this slot is empty or its contents move on
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    blk_d   = blk_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
    if (in_ready_o && in_valid_i) begin
      blk_d.w0 = update_first ? res : in_blk_i.w0;
      blk_d.w1 = update_first ? in_blk_i.w1 : res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  assign out_valid_o = valid_q;
  assign out_blk_o   = blk_q;

`ifndef NO_ASSERTIONS
  // A stalled cell keeps its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(blk_q))
    else $error("stalled cell lost or changed its transaction");

  // An accepted transaction occupies the cell next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q)
    else $error("accepted transaction not held in cell");
`endif

endmodule
